>>> rtl/core/eil4hp_pkg.sv
// Shared types, constants and helpers for the Ethernet/IPv4/L4 header parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package eil4hp_pkg;

  localparam int unsigned LEN_BITS_DEF = 16;
  localparam int unsigned FRAME_LEN_W  = 16;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [15:0] MAX_PAY_RST   = 16'd1500;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [3:0]  IHL_MIN       = 4'd5;
  localparam logic [3:0]  TCP_OFF_MIN   = 4'd5;
  localparam logic [6:0]  ETH_HDR_LEN   = 7'd14;
  localparam logic [6:0]  IPV4_HDR_END  = 7'd34;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [47:0]            dst_mac;
    logic [47:0]            src_mac;
    logic                   is_ipv4;
    logic [7:0]             ip_protocol;
    logic [31:0]            src_ip;
    logic [31:0]            dst_ip;
    logic                   has_ports;
    logic [15:0]            l4_sport;
    logic [15:0]            l4_dport;
    logic [15:0]            payload_len;
    logic                   truncated;
    logic [FRAME_LEN_W-1:0] frame_len;
  } result_t;

  // Raw capture of one frame, handed from front to back.
  typedef struct packed {
    logic [47:0]            dst_mac;
    logic [47:0]            src_mac;
    logic                   etype_ok;
    logic [3:0]             ihl;
    logic [7:0]             protocol;
    logic [31:0]            src_ip;
    logic [31:0]            dst_ip;
    logic [15:0]            l4_sport;
    logic [15:0]            l4_dport;
    logic [3:0]             tcp_off;
    logic [FRAME_LEN_W-1:0] frame_len;
  } frame_rec_t;

  typedef struct packed {
    logic       push;
    frame_rec_t rec;
  } q_wr_t;

  // Start of the layer-4 header: 14 + 4*IHL, IHL floored at 5. Range 34..74.
  function automatic logic [6:0] l4_start(input logic [3:0] ihl);
    logic [3:0] ihl_e;
    ihl_e = (ihl < IHL_MIN) ? IHL_MIN : ihl;
    return ETH_HDR_LEN + {1'b0, ihl_e, 2'b00};
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/eil4hp_front.sv
// Front end: counts frame bytes and captures header fields by position.
// Depends on eil4hp_pkg; pushes one frame record per frame into the queue.
`default_nettype none

module eil4hp_front
  import eil4hp_pkg::*;
#(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  input  wire in_item_t in_item_i,
  input  wire logic     q_full_i,
  output q_wr_t         q_wr_o
);

  localparam logic [LEN_BITS-1:0] CntCap = '1;

  logic [LEN_BITS-1:0] cnt_q, cnt_d;
  logic [47:0] dmac_q, dmac_d, smac_q, smac_d;
  logic [15:0] etype_q, etype_d;
  logic [3:0]  ihl_q, ihl_d, toff_q, toff_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] sip_q, sip_d, dip_q, dip_d;
  logic [15:0] sport_q, sport_d, dport_q, dport_d;
  logic [LEN_BITS-1:0] l4;
  logic [7:0]  b;
  logic        accept;

  assign b      = in_item_i.data_byte;
  assign accept = push && !q_full_i;
  assign l4     = LEN_BITS'(l4_start(ihl_q));
  assign cnt_d  = (cnt_q != CntCap) ? cnt_q + LEN_BITS'(1) : cnt_q;

  always_comb begin
    dmac_d  = dmac_q;
    smac_d  = smac_q;
    etype_d = etype_q;
    ihl_d   = ihl_q;
    proto_d = proto_q;
    sip_d   = sip_q;
    dip_d   = dip_q;
    sport_d = sport_q;
    dport_d = dport_q;
    toff_d  = toff_q;
    for (int i = 0; i < 6; i++) begin
      if (cnt_q == LEN_BITS'(i))     dmac_d[8*(5-i) +: 8] = b;
      if (cnt_q == LEN_BITS'(i + 6)) smac_d[8*(5-i) +: 8] = b;
    end
    for (int i = 0; i < 2; i++) begin
      if (cnt_q == LEN_BITS'(i + 12)) etype_d[8*(1-i) +: 8] = b;
    end
    if (etype_q == ETH_TYPE_IPV4) begin
      if (cnt_q == LEN_BITS'(14)) ihl_d   = b[3:0];
      if (cnt_q == LEN_BITS'(23)) proto_d = b;
      for (int i = 0; i < 4; i++) begin
        if (cnt_q == LEN_BITS'(i + 26)) sip_d[8*(3-i) +: 8] = b;
        if (cnt_q == LEN_BITS'(i + 30)) dip_d[8*(3-i) +: 8] = b;
      end
      if (proto_q == IP_PROTO_TCP || proto_q == IP_PROTO_UDP) begin
        for (int i = 0; i < 2; i++) begin
          if (cnt_q == l4 + LEN_BITS'(i))     sport_d[8*(1-i) +: 8] = b;
          if (cnt_q == l4 + LEN_BITS'(i + 2)) dport_d[8*(1-i) +: 8] = b;
        end
        if (proto_q == IP_PROTO_TCP && cnt_q == l4 + LEN_BITS'(12)) toff_d = b[7:4];
      end
    end
  end

  always_comb begin
    q_wr_o.push              = accept && in_item_i.last_byte;
    q_wr_o.rec.dst_mac       = dmac_d;
    q_wr_o.rec.src_mac       = smac_d;
    q_wr_o.rec.etype_ok      = (etype_d == ETH_TYPE_IPV4);
    q_wr_o.rec.ihl           = ihl_d;
    q_wr_o.rec.protocol      = proto_d;
    q_wr_o.rec.src_ip        = sip_d;
    q_wr_o.rec.dst_ip        = dip_d;
    q_wr_o.rec.l4_sport      = sport_d;
    q_wr_o.rec.l4_dport      = dport_d;
    q_wr_o.rec.tcp_off       = toff_d;
    q_wr_o.rec.frame_len     = FRAME_LEN_W'(cnt_d);
  end

  // Frame state clears on the last beat, ready for the next frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      dmac_q  <= '0;
      smac_q  <= '0;
      etype_q <= '0;
      ihl_q   <= '0;
      proto_q <= '0;
      sip_q   <= '0;
      dip_q   <= '0;
      sport_q <= '0;
      dport_q <= '0;
      toff_q  <= '0;
    end else if (accept) begin
      if (in_item_i.last_byte) begin
        cnt_q   <= '0;
        dmac_q  <= '0;
        smac_q  <= '0;
        etype_q <= '0;
        ihl_q   <= '0;
        proto_q <= '0;
        sip_q   <= '0;
        dip_q   <= '0;
        sport_q <= '0;
        dport_q <= '0;
        toff_q  <= '0;
      end else begin
        cnt_q   <= cnt_d;
        dmac_q  <= dmac_d;
        smac_q  <= smac_d;
        etype_q <= etype_d;
        ihl_q   <= ihl_d;
        proto_q <= proto_d;
        sip_q   <= sip_d;
        dip_q   <= dip_d;
        sport_q <= sport_d;
        dport_q <= dport_d;
        toff_q  <= toff_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/eil4hp_fifo.sv
// Short record queue between front and back of the header parser.
// Depends on eil4hp_pkg for the record type and depth.
`default_nettype none

module eil4hp_fifo
  import eil4hp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire q_wr_t q_wr_i,
  input  wire logic  pop_i,
  output logic       full_o,
  output logic       empty_o,
  output frame_rec_t head_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  frame_rec_t          slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wptr_q, rptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                wr, rd;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr      = q_wr_i.push && !full_o;
  assign rd      = pop_i && !empty_o;
  assign head_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      slot_q[wptr_q] <= q_wr_i.rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) begin
        wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
      end
      if (rd) begin
        rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // No write is ever dropped: the front stalls on full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr_i.push |-> !full_o)
    else $error("eil4hp_fifo: write while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && !rd |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("eil4hp_fifo: fill count missed a write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !full_o |-> (wptr_q != rptr_q))
    else $error("eil4hp_fifo: pointers disagree with fill count");

endmodule

`default_nettype wire

>>> rtl/core/eil4hp_back.sv
// Back end: turns a captured frame record into a summary and holds it for pop.
// Depends on eil4hp_pkg; owns the max_payload_len register.
`default_nettype none

module eil4hp_back
  import eil4hp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        q_empty_i,
  input  wire frame_rec_t  head_i,
  output logic             q_pop_o,
  input  wire logic        pop,
  output logic             empty,
  output result_t          res_o
);

  logic [15:0]            max_pay_q;
  logic                   valid_q;
  result_t                res_q, res_d;
  logic [FRAME_LEN_W-1:0] n;
  logic [6:0]             l4;
  logic [3:0]             toff_e;
  logic [7:0]             hs;
  logic                   ipv4, tcp, udp, l4_full, ports, trunc;
  logic [FRAME_LEN_W-1:0] diff;
  logic [15:0]            pay;

  assign n      = head_i.frame_len;
  assign l4     = l4_start(head_i.ihl);
  assign ipv4   = (n >= FRAME_LEN_W'(ETH_HDR_LEN)) && head_i.etype_ok;
  assign tcp    = ipv4 && (head_i.protocol == IP_PROTO_TCP);
  assign udp    = ipv4 && (head_i.protocol == IP_PROTO_UDP);
  assign l4_full = (n >= FRAME_LEN_W'(l4) + FRAME_LEN_W'(4));
  assign ports  = (tcp || udp) && l4_full;
  assign trunc  = (n < FRAME_LEN_W'(ETH_HDR_LEN))
               || (ipv4 && n < FRAME_LEN_W'(IPV4_HDR_END))
               || ((tcp || udp) && !l4_full)
               || (tcp && n < FRAME_LEN_W'(l4) + FRAME_LEN_W'(13));
  assign toff_e = (head_i.tcp_off < TCP_OFF_MIN) ? TCP_OFF_MIN : head_i.tcp_off;
  assign hs     = tcp ? {1'b0, l4} + {2'b00, toff_e, 2'b00} : {1'b0, l4} + 8'd8;
  assign diff   = (n > FRAME_LEN_W'(hs)) ? n - FRAME_LEN_W'(hs) : '0;

  always_comb begin
    pay = '0;
    if (ports && !trunc) begin
      pay = (16'(diff) > max_pay_q) ? max_pay_q : 16'(diff);
    end
    res_d.dst_mac     = head_i.dst_mac;
    res_d.src_mac     = head_i.src_mac;
    res_d.is_ipv4     = ipv4;
    res_d.ip_protocol = ipv4 ? head_i.protocol : '0;
    res_d.src_ip      = ipv4 ? head_i.src_ip : '0;
    res_d.dst_ip      = ipv4 ? head_i.dst_ip : '0;
    res_d.has_ports   = ports;
    res_d.l4_sport    = ports ? head_i.l4_sport : '0;
    res_d.l4_dport    = ports ? head_i.l4_dport : '0;
    res_d.payload_len = pay;
    res_d.truncated   = trunc;
    res_d.frame_len   = n;
  end

  // Output stage refills in the same cycle it is popped, if the queue holds a record.
  assign q_pop_o = !q_empty_i && (!valid_q || pop);
  assign empty   = !valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      max_pay_q <= MAX_PAY_RST;
    end else begin
      if (cfg_we_i) begin
        max_pay_q <= cfg_wdata_i;
      end
      if (q_pop_o) begin
        valid_q <= 1'b1;
      end else if (pop) begin
        valid_q <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !res_q.has_ports |-> res_q.payload_len == '0)
    else $error("eil4hp_back: payload length without ports");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.has_ports |-> res_q.is_ipv4)
    else $error("eil4hp_back: ports on a non-IPv4 frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.is_ipv4 |-> res_q.frame_len >= FRAME_LEN_W'(ETH_HDR_LEN))
    else $error("eil4hp_back: IPv4 flagged on a short frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !res_q.is_ipv4 |-> res_q.ip_protocol == '0 && res_q.src_ip == '0)
    else $error("eil4hp_back: IPv4 fields leak on a non-IPv4 frame");

endmodule

`default_nettype wire

>>> rtl/core/eth_ipv4_l4_header_parser.sv
// Ethernet/IPv4/TCP-UDP header parser, one frame byte per beat, one summary per frame.
// Throughput: one byte every cycle while full is low; a summary per cycle at most
//   (frames of one byte). The edge that takes the last byte writes the record queue;
//   the back output register takes the record once free, which puts it on res_o.
// Reset: all frame state and queues empty, max_payload_len back to 1500.
// Depends on eil4hp_pkg, eil4hp_front, eil4hp_fifo, eil4hp_back.
`default_nettype none

module eth_ipv4_l4_header_parser
  import eil4hp_pkg::*;
#(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte side: queue-like, a beat is taken on push && !full
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_item_i,
  // summary side: head of the result queue while !empty
  output logic             empty,
  input  wire logic        pop,
  output result_t          res_o,
  // max_payload_len write port
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  q_wr_t      q_wr;
  logic       q_full, q_empty, q_pop;
  frame_rec_t q_head;

  // The front stalls the byte side while the record queue is full; with the
  // back draining one record per cycle this only happens under result back-pressure.
  assign full = q_full;

  eil4hp_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .q_wr_o    (q_wr)
  );

  // Decouples header capture from the summary stage.
  eil4hp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_wr_i  (q_wr),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // Length arithmetic, clamp and output register.
  eil4hp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_empty_i   (q_empty),
    .head_i      (q_head),
    .q_pop_o     (q_pop),
    .pop         (pop),
    .empty       (empty),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

>>> sim/tb_eth_ipv4_l4_header_parser.sv
// Testbench for eth_ipv4_l4_header_parser: frames go in a beat at a time, and each summary
// is checked against a local byte-position parser.
// Depends on eil4hp_pkg and the RTL of the block; self-contained otherwise.
`timescale 1ns / 1ps

module tb_eth_ipv4_l4_header_parser;
  import eil4hp_pkg::*;

  localparam int IDLE_PCT    = 18;     // chance of a gap / stall per beat, in percent
  localparam int QUIET_LIMIT = 2000;   // cycles with no beat on either side before giving up
  localparam int LEN_CAP     = (1 << LEN_BITS_DEF) - 1;
  localparam int ITEM_TARGET = 1450;   // bytes sent over the whole run

  logic        clk_i;
  logic        rst_ni;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  result_t     res_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  eth_ipv4_l4_header_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------------------
  // Local parser state: mirrors what the block has captured of the frame in flight.
  // ---------------------------------------------------------------------------------------
  logic [15:0] max_pay = MAX_PAY_RST;
  logic [15:0] p_count;
  logic [47:0] p_dst_mac, p_src_mac;
  logic [15:0] p_etype;
  logic [3:0]  p_ihl, p_tcp_off;
  logic [7:0]  p_proto;
  logic [31:0] p_src_ip, p_dst_ip;
  logic [15:0] p_sport, p_dport;

  result_t     pending_summaries[$];   // summaries owed by the block, oldest first
  result_t     head_summary;
  logic [7:0]  frame_buf[$];           // frame being built for sending

  int errors = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int summaries_checked = 0;
  bit no_idle = 1'b0;
  bit no_stall = 1'b0;

  // start of the layer-4 header; IHL below the minimum is read as the minimum
  function automatic int l4_offset(input logic [3:0] ihl);
    return 14 + 4 * ((ihl < IHL_MIN) ? int'(IHL_MIN) : int'(ihl));
  endfunction

  // layer-4 header length: TCP from its data offset (floored), UDP fixed
  function automatic int l4_hdr_len(input logic [7:0] proto, input logic [3:0] toff);
    if (proto == IP_PROTO_TCP) return 4 * ((toff < TCP_OFF_MIN) ? int'(TCP_OFF_MIN) : int'(toff));
    return 8;
  endfunction

  function automatic void clear_frame_state();
    p_count = '0; p_dst_mac = '0; p_src_mac = '0; p_etype = '0; p_ihl = '0;
    p_proto = '0; p_src_ip = '0; p_dst_ip = '0; p_sport = '0; p_dport = '0;
    p_tcp_off = '0;
  endfunction

  // Takes one accepted byte; on the last byte of a frame queues the expected summary.
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    int pos, n, l4, hs, pay;
    bit ipv4, tcp, udp, ports, trunc;
    result_t r;
    pos = p_count;
    if (pos < 6) p_dst_mac[8*(5-pos) +: 8] = b;
    else if (pos < 12) p_src_mac[8*(11-pos) +: 8] = b;
    else if (pos < 14) p_etype[8*(13-pos) +: 8] = b;
    else if (p_etype == ETH_TYPE_IPV4) begin
      if (pos == 14) p_ihl = b[3:0];
      if (pos == 23) p_proto = b;
      if (pos >= 26 && pos < 30) p_src_ip[8*(29-pos) +: 8] = b;
      if (pos >= 30 && pos < 34) p_dst_ip[8*(33-pos) +: 8] = b;
      l4 = l4_offset(p_ihl);
      if (p_proto == IP_PROTO_TCP || p_proto == IP_PROTO_UDP) begin
        if (pos >= l4 && pos < l4 + 2) p_sport[8*(l4+1-pos) +: 8] = b;
        if (pos >= l4 + 2 && pos < l4 + 4) p_dport[8*(l4+3-pos) +: 8] = b;
        if (p_proto == IP_PROTO_TCP && pos == l4 + 12) p_tcp_off = b[7:4];
      end
    end
    if (int'(p_count) < LEN_CAP) p_count++;   // saturates on very long frames
    if (!last) return;

    n     = p_count;
    l4    = l4_offset(p_ihl);
    ipv4  = (n >= 14) && (p_etype == ETH_TYPE_IPV4);
    tcp   = ipv4 && (p_proto == IP_PROTO_TCP);
    udp   = ipv4 && (p_proto == IP_PROTO_UDP);
    trunc = (n < 14) || (ipv4 && n < int'(IPV4_HDR_END));
    ports = 1'b0;
    if (tcp || udp) begin
      if (n < l4 + 4) trunc = 1'b1;
      else ports = 1'b1;
    end
    if (tcp && n < l4 + 13) trunc = 1'b1;   // data-offset byte missing
    pay = 0;
    if (ports && !trunc) begin
      hs  = l4 + l4_hdr_len(p_proto, p_tcp_off);
      pay = (n > hs) ? n - hs : 0;
      if (pay > int'(max_pay)) pay = max_pay;
    end

    r.dst_mac     = p_dst_mac;
    r.src_mac     = p_src_mac;
    r.is_ipv4     = ipv4;
    r.ip_protocol = ipv4 ? p_proto : '0;
    r.src_ip      = ipv4 ? p_src_ip : '0;
    r.dst_ip      = ipv4 ? p_dst_ip : '0;
    r.has_ports   = ports;
    r.l4_sport    = ports ? p_sport : '0;
    r.l4_dport    = ports ? p_dport : '0;
    r.payload_len = pay[15:0];
    r.truncated   = trunc;
    r.frame_len   = n[FRAME_LEN_W-1:0];
    pending_summaries.push_back(r);
    clear_frame_state();
  endfunction

  // ---------------------------------------------------------------------------------------
  // Summary side: random pop stalls, every accepted summary checked field by field.
  // ---------------------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: summary %0d %s mismatch: expected %0h actual %0h",
               $time, summaries_checked, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    pop <= no_stall || ($urandom_range(99) >= IDLE_PCT);
    if (rst_ni && pop && !empty) begin
      if (pending_summaries.size() == 0) begin
        errors++;
        $display("%0t: unexpected summary: expected none actual %0h", $time, res_o);
      end else begin
        head_summary = pending_summaries.pop_front();
        check_field("dst_mac",     head_summary.dst_mac,     res_o.dst_mac);
        check_field("src_mac",     head_summary.src_mac,     res_o.src_mac);
        check_field("is_ipv4",     head_summary.is_ipv4,     res_o.is_ipv4);
        check_field("ip_protocol", head_summary.ip_protocol, res_o.ip_protocol);
        check_field("src_ip",      head_summary.src_ip,      res_o.src_ip);
        check_field("dst_ip",      head_summary.dst_ip,      res_o.dst_ip);
        check_field("has_ports",   head_summary.has_ports,   res_o.has_ports);
        check_field("l4_sport",    head_summary.l4_sport,    res_o.l4_sport);
        check_field("l4_dport",    head_summary.l4_dport,    res_o.l4_dport);
        check_field("payload_len", head_summary.payload_len, res_o.payload_len);
        check_field("truncated",   head_summary.truncated,   res_o.truncated);
        check_field("frame_len",   head_summary.frame_len,   res_o.frame_len);
        summaries_checked++;
      end
    end
  end

  // Watchdog: ends the run if neither side moves a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("** eth_ipv4_l4_header_parser: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Byte side
  // ---------------------------------------------------------------------------------------
  // One beat: optional random gap, then hold push until the block takes the byte.
  task automatic send_octet(input logic [7:0] value, input logic last);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= '{data_byte: value, last_byte: last};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    parse_byte(value, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      send_octet(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  // Frame of len bytes: random (fill < 0) or constant filler, with EtherType, IHL, protocol
  // and TCP data offset placed at their positions where the length reaches them.
  task automatic make_frame(input logic [15:0] etype, input logic [3:0] ihl,
                            input logic [7:0] proto, input logic [3:0] toff,
                            input int len, input int fill);
    int l4;
    frame_buf.delete();
    for (int i = 0; i < len; i++)
      frame_buf.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
    l4 = l4_offset(ihl);
    if (len > 12) frame_buf[12] = etype[15:8];
    if (len > 13) frame_buf[13] = etype[7:0];
    if (etype == ETH_TYPE_IPV4) begin
      if (len > 14) frame_buf[14] = {frame_buf[14][7:4], ihl};
      if (len > 23) frame_buf[23] = proto;
      if (len > l4 + 12) frame_buf[l4+12] = {toff, frame_buf[l4+12][3:0]};
    end
  endtask

  task automatic frame(input logic [15:0] etype, input logic [3:0] ihl, input logic [7:0] proto,
                       input logic [3:0] toff, input int len, input int fill = -1);
    make_frame(etype, ihl, proto, toff, len, fill);
    send_frame();
  endtask

  // Stop pushing, let every owed summary come out, then wait out the output path.
  task automatic wait_drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_summaries.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Only called with the block idle (after wait_drain).
  task automatic write_max_payload(input logic [15:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_pay   = value;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------
  // Clamp straight out of reset is 1500: a 100-byte TCP frame keeps all 46 payload bytes.
  task automatic test_reset_clamp();
    frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_TCP, 4'd5, 100);
    wait_drain();
  endtask

  // Frames that stop inside the Ethernet header, or right at its end.
  task automatic test_short_ethernet();
    frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 4'd5, 1);
    frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 4'd5, 13);
    frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 4'd5, 14);
    frame(16'h86DD, 4'd5, IP_PROTO_UDP, 4'd5, 14);
    wait_drain();
  endtask

  // IPv4 header cut short (partial addresses still reported, truncation flagged), then complete with protocol 1.
  task automatic test_short_ipv4();
    frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 4'd5, 20);
    frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 4'd5, 33);
    frame(ETH_TYPE_IPV4, 4'd5, 8'd1, 4'd5, 34);
    frame(ETH_TYPE_IPV4, 4'd5, 8'd1, 4'd5, 60);
    wait_drain();
  endtask

  // Layer-4 cases: partial ports, TCP ending before its offset byte, IHL and data offset
  // below the minimum and at the maximum.
  task automatic test_layer4();
    frame(ETH_TYPE_IPV4, 4'd5,  IP_PROTO_UDP, 4'd5,  37);
    frame(ETH_TYPE_IPV4, 4'd5,  IP_PROTO_UDP, 4'd5,  42);
    frame(ETH_TYPE_IPV4, 4'd5,  IP_PROTO_UDP, 4'd5,  50);
    frame(ETH_TYPE_IPV4, 4'd5,  IP_PROTO_TCP, 4'd5,  46);
    frame(ETH_TYPE_IPV4, 4'd5,  IP_PROTO_TCP, 4'd5,  60);
    frame(ETH_TYPE_IPV4, 4'd0,  IP_PROTO_TCP, 4'd0,  70);
    frame(ETH_TYPE_IPV4, 4'd15, IP_PROTO_TCP, 4'd15, 150);
    frame(ETH_TYPE_IPV4, 4'd5,  IP_PROTO_TCP, 4'd15, 47);
    wait_drain();
  endtask

  // All-zero and all-one bytes, inside and outside IPv4.
  task automatic test_byte_extremes();
    frame(16'hFFFF, 4'd5, IP_PROTO_UDP, 4'd5, 40, 8'hFF);
    frame(16'h0000, 4'd5, IP_PROTO_UDP, 4'd5, 40, 8'h00);
    frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 4'd5, 60, 8'hFF);
    frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_TCP, 4'd5, 60, 8'h00);
    wait_drain();
  endtask

  // Clamp at both extremes and a small value; 60-byte UDP frames carry 18 payload bytes.
  task automatic test_payload_clamp();
    write_max_payload(16'd0);
    frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 4'd5, 60);
    wait_drain();
    write_max_payload(16'hFFFF);
    frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 4'd5, 60);
    wait_drain();
    write_max_payload(16'd10);
    frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 4'd5, 60);
    wait_drain();
  endtask

  // Random frames in phases, each with its own clamp; one phase runs with no gaps at all.
  // Most frames are well-formed TCP/UDP with lengths around the header boundaries.
  task automatic test_random();
    int start_bytes, budget, kind, len, hs;
    logic [3:0]  ihl, toff;
    logic [7:0]  proto;
    logic [15:0] etype;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_max_payload(16'($urandom_range(65535)));
        1: write_max_payload(16'($urandom_range(40)));
        2: write_max_payload(16'hFFFF);
        default: write_max_payload(16'($urandom_range(200)));
      endcase
      no_idle      = (phase == 2);
      no_stall     = (phase == 2);
      start_bytes  = bytes_sent;
      budget       = (ITEM_TARGET - bytes_sent) / (4 - phase);
      while (bytes_sent - start_bytes < budget) begin
        kind = $urandom_range(99);
        ihl  = ($urandom_range(9) < 6) ? 4'd5 : 4'($urandom_range(15));
        toff = ($urandom_range(9) < 6) ? 4'd5 : 4'($urandom_range(15));
        if (kind < 70) begin
          proto = $urandom_range(1) ? IP_PROTO_TCP : IP_PROTO_UDP;
          hs    = l4_offset(ihl) + l4_hdr_len(proto, toff);
          len   = ($urandom_range(3) == 0) ? $urandom_range(1, hs) : $urandom_range(hs, hs + 40);
          etype = ETH_TYPE_IPV4;
        end else if (kind < 85) begin
          proto = 8'($urandom_range(255));
          etype = $urandom_range(1) ? ETH_TYPE_IPV4 : 16'($urandom_range(65535));
          len   = $urandom_range(1, 80);
        end else begin
          // noise: nothing placed beyond a random EtherType
          proto = 8'($urandom_range(255));
          etype = 16'($urandom_range(65535));
          len   = $urandom_range(1, 40);
        end
        frame(etype, ihl, proto, toff, len);
      end
      wait_drain();
    end
    no_idle  = 1'b0;
    no_stall = 1'b0;
  endtask

  initial begin
    clear_frame_state();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_clamp();
    test_short_ethernet();
    test_short_ipv4();
    test_layer4();
    test_byte_extremes();
    test_payload_clamp();
    test_random();

    $display("Sent %0d frames (%0d bytes), %0d summaries checked, %0d errors.",
             frames_sent, bytes_sent, summaries_checked, errors);
    $display("Covered short headers, IHL/offset floors, clamp 0..65535, random frames.");
    if (errors == 0) begin
      $display("** eth_ipv4_l4_header_parser: PASSED **");
    end else begin
      $display("** eth_ipv4_l4_header_parser: FAILED **");
    end
    $finish;
  end

endmodule
